// ===== design/xoshiro128p_generator_bank_macros.svh =====
// assertion macros for the generator bank
`ifndef XOSHIRO128P_GENERATOR_BANK_MACROS_SVH
`define XOSHIRO128P_GENERATOR_BANK_MACROS_SVH

// assert that a implies b on the same edge
`define XGB_ASSERT_IMP(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// assert that a implies b on the next edge
`define XGB_ASSERT_NEXT(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ===== design/xgb_pkg.sv =====
// ----------------------------------------------------------------------------
// xgb_pkg
// shared types and constants for the generator bank
// ----------------------------------------------------------------------------
`default_nettype none
package xgb_pkg;
  localparam int DefNumGen = 64;
  localparam logic [63:0] Golden = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] Mix1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] Mix2   = 64'h94d049bb133111eb;
  localparam logic [1:0] FuncSeed  = 2'd0;
  localparam logic [1:0] FuncRange = 2'd1;
  localparam logic [1:0] FuncSym   = 2'd2;
  localparam logic [1:0] FuncNone  = 2'd3;
  localparam logic [0:0] RegSeed = 1'b0;

  // datapath commands
  typedef struct packed {
    logic load;      // capture input item, start read
    logic mul;       // start a multiply step
    logic mix_done;  // not used as command; reserved bits kept narrow
  } xgb_dummy_t;

  typedef struct packed {
    logic load;       // capture input item and issue ram read
    logic seed_step;  // one splitmix step
    logic adv;        // advance captured words
    logic mul;        // multiply step
    logic fin;        // result strobe; not used by the datapath
    logic wr;         // write words back
    logic out_set;    // present result
  } xgb_cmd_t;

  typedef struct packed {
    logic is_seed;
    logic is_nop;
    logic seed_last;
  } xgb_sts_t;
endpackage
`default_nettype wire

// ===== design/xgb_if.sv =====
// ----------------------------------------------------------------------------
// xgb_if
// valid/ready channel carrying one item
// ----------------------------------------------------------------------------
`default_nettype none
interface xgb_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/xgb_ram.sv =====
// ----------------------------------------------------------------------------
// xgb_ram
// ram with one write port and one read port, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module xgb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  // storage and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/xgb_datapath.sv =====
// ----------------------------------------------------------------------------
// xgb_datapath
// splitmix seeding, xoshiro step, fixed-point scaling and state ram
// ----------------------------------------------------------------------------
`default_nettype none
module xgb_datapath
  import xgb_pkg::*;
#(
  parameter int NumGen = DefNumGen
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire xgb_cmd_t    cmd,
  output      xgb_sts_t    sts,
  input  wire logic [63:0] seed,
  input  wire logic [1:0]  func,
  input  wire logic [5:0]  index,
  input  wire logic [31:0] low_bound,
  input  wire logic [31:0] scale,
  output      logic [31:0] value_r,
  output      logic [31:0] raw_r
);
  localparam int AW = (NumGen > 1) ? $clog2(NumGen) : 1;

  logic [1:0]  func_r;
  logic [5:0]  idx_r;
  logic [31:0] lo_r, sc_r;
  logic [31:0] w0_r, w1_r, w2_r, w3_r;
  logic [31:0] res_r;
  logic [63:0] z_r, z1_r, x_r, pl_r;
  logic [31:0] ph_r;
  logic [3:0]  phase_r;
  logic        round_r;
  logic [63:0] prod_r;
  logic [127:0] rdata;
  logic [AW-1:0] addr;
  logic [63:0] mconst;
  logic [31:0] ma, mb;
  logic [63:0] mprod;
  logic [63:0] z_fin;
  logic [31:0] v_fin;
  logic signed [32:0] mult_b;
  logic signed [65:0] mult_full;
  logic signed [40:0] shifted;

  assign addr = AW'(idx_r);

  xgb_ram #(.Width(128), .Depth(NumGen)) u_ram (
    .clk(clk), .we(cmd.wr), .waddr(addr), .wdata({w3_r, w2_r, w1_r, w0_r}),
    .raddr(addr), .rdata(rdata)
  );

  assign sts.is_seed   = (func_r == FuncSeed);
  assign sts.is_nop    = (func_r == FuncNone) || ({26'd0, idx_r} >= 32'(NumGen));
  assign sts.seed_last = round_r && (phase_r == 4'd8);

  // splitmix multiply: 64-bit low product from three 32-bit partial products
  assign mconst = (phase_r < 4'd4) ? Mix1 : Mix2;
  always_comb begin
    unique case (phase_r)
      4'd2, 4'd6: begin
        ma = x_r[31:0]; mb = mconst[63:32];
      end
      4'd3, 4'd7: begin
        ma = x_r[63:32]; mb = mconst[31:0];
      end
      default: begin
        ma = x_r[31:0]; mb = mconst[31:0];
      end
    endcase
  end
  assign mprod = ma * mb;
  assign z_fin = z_r ^ (z_r >> 31);

  // fixed-point multiply of scale by the fraction
  assign mult_b = (func_r == FuncRange) ? $signed({10'd0, res_r[31:9]})
                                        : $signed({9'd0, res_r[31:9], 1'b0}) - 33'sd8388608;
  assign mult_full = $signed(sc_r) * mult_b;
  assign shifted = $signed(prod_r[63:23]);

  always_comb begin
    if (shifted > 41'sd2147483647) v_fin = 32'h7fffffff;
    else v_fin = shifted[31:0];
    if (func_r == FuncRange && $signed(v_fin) < $signed(lo_r)) v_fin = lo_r;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 4'd0;
      round_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        phase_r <= 4'd0;
        round_r <= 1'b0;
      end else if (cmd.seed_step) begin
        if (phase_r == 4'd8) begin
          phase_r <= 4'd0;
          round_r <= 1'b1;
        end else begin
          phase_r <= phase_r + 4'd1;
        end
      end
    end
    if (cmd.load) begin
      func_r <= func; idx_r <= index; lo_r <= low_bound; sc_r <= scale;
    end
    if (cmd.seed_step) begin
      unique case (phase_r)
        4'd0:       x_r <= z_r ^ (z_r >> 30);
        4'd4:       x_r <= z_r ^ (z_r >> 27);
        4'd1, 4'd5: pl_r <= mprod;
        4'd2, 4'd6: ph_r <= pl_r[63:32] + mprod[31:0];
        4'd3, 4'd7: z_r <= {ph_r + mprod[31:0], pl_r[31:0]};
        default: begin
          // end of a round: first gives words 0 and 1, second words 2 and 3
          if (!round_r) begin
            z1_r <= z_fin;
            z_r  <= z_fin + Golden;
          end else begin
            w0_r <= z1_r[31:0]; w1_r <= z1_r[63:32];
            w2_r <= z_fin[31:0]; w3_r <= z_fin[63:32];
          end
        end
      endcase
    end else if (cmd.load) begin
      z_r <= seed + {58'd0, index} * Golden;
    end
    if (cmd.adv) begin
      res_r <= rdata[31:0] + rdata[127:96];
      w2_r <= rdata[95:64] ^ rdata[31:0] ^ {rdata[54:32], 9'd0};
      w3_r <= {(rdata[127:96] ^ rdata[63:32]) << 11}
            | ((rdata[127:96] ^ rdata[63:32]) >> 21);
      w1_r <= rdata[63:32] ^ rdata[95:64] ^ rdata[31:0];
      w0_r <= rdata[31:0] ^ rdata[127:96] ^ rdata[63:32];
    end
    if (cmd.mul) prod_r <= mult_full[63:0];
    if (cmd.out_set) begin
      value_r <= (sts.is_nop || sts.is_seed) ? 32'd0 : v_fin;
      raw_r   <= (sts.is_nop || sts.is_seed) ? 32'd0 : res_r;
    end
  end

  logic unused;
  assign unused = cmd.fin;
endmodule
`default_nettype wire

// ===== design/xgb_ctrl.sv =====
// ----------------------------------------------------------------------------
// xgb_ctrl
// sequencer for seed and generate items
// ----------------------------------------------------------------------------
`default_nettype none
module xgb_ctrl
  import xgb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_ready,
  output      logic     out_valid,
  input  wire logic     out_ready,
  output      xgb_cmd_t cmd,
  input  wire xgb_sts_t sts
);
`include "xoshiro128p_generator_bank_macros.svh"
  typedef enum logic [5:0] {
    IDLE = 6'b000001, READ = 6'b000010, ADV = 6'b000100,
    MUL  = 6'b001000, SEED = 6'b010000, DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  assign out_valid = ovalid_r;
  // a new item may enter in IDLE, also while the last result waits; not while one is held at DONE
  assign in_ready = (state_r == IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ovalid_nxt = ovalid_r && !out_ready;
    unique case (state_r)
      IDLE: if (in_valid) begin
        cmd.load = 1'b1; state_nxt = READ;
      end
      READ: begin
        if (sts.is_nop) state_nxt = DONE;
        else if (sts.is_seed) state_nxt = SEED;
        else state_nxt = ADV;
      end
      ADV: begin
        cmd.adv = 1'b1; state_nxt = MUL;
      end
      MUL: begin
        cmd.mul = 1'b1; cmd.wr = 1'b1; state_nxt = DONE;
      end
      SEED: begin
        cmd.seed_step = 1'b1;
        if (sts.seed_last) state_nxt = MUL;
      end
      DONE: if (!ovalid_r || out_ready) begin
        cmd.out_set = 1'b1; cmd.fin = 1'b1; ovalid_nxt = 1'b1; state_nxt = IDLE;
      end
      default: state_nxt = IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ovalid_r <= ovalid_nxt;
    end
  end

  `XGB_ASSERT_IMP(a_onehot, 1'b1, $onehot(state_r), "state not one-hot")
  `XGB_ASSERT_NEXT(a_load_read, cmd.load, state_r == READ, "load not followed by read")
  `XGB_ASSERT_IMP(a_wr_gen, cmd.wr, state_r == MUL, "write outside mul")
endmodule
`default_nettype wire

// ===== design/xoshiro128p_generator_bank.sv =====
// ----------------------------------------------------------------------------
// xoshiro128p_generator_bank
// bank of xoshiro128+ generators with splitmix seeding and Q16.16 scaling
// ----------------------------------------------------------------------------
// A generate item passes through transfer, ram read, step, multiply and
// result, and its result is then held in the output register until taken.
// A seed item runs the eighteen splitmix steps; each 64-bit multiply is
// built from three 32-bit partial products. One item is handled at a time;
// a new one is taken only once the last has left the result step, and the
// result register lets the next item enter while that result waits.
`default_nettype none
module xoshiro128p_generator_bank
  import xgb_pkg::*;
#(
  parameter int NumGen = DefNumGen
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  xgb_if.sink              in_ch,
  xgb_if.source            out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [0:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output      logic [63:0] cfg_prdata,
  output      logic        cfg_pready
);
  logic [63:0] seed_r;
  xgb_cmd_t cmd;
  xgb_sts_t sts;
  logic [31:0] value_r, raw_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == RegSeed) ? seed_r : 64'd0;

  // seed register write
  always_ff @(posedge clk) begin
    if (!rst_n) seed_r <= 64'd0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == RegSeed)
      seed_r <= cfg_pwdata;
  end

  xgb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd), .sts(sts)
  );

  xgb_datapath #(.NumGen(NumGen)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .seed(seed_r),
    .func(in_ch.data[1:0]), .index(in_ch.data[7:2]),
    .low_bound(in_ch.data[39:8]), .scale(in_ch.data[71:40]),
    .value_r(value_r), .raw_r(raw_r)
  );

  assign out_ch.data = {raw_r, value_r};
endmodule
`default_nettype wire
